/* rtl/hne_pkg.sv */
// shared types and constants for the heightmap normal engine
// no dependencies; used by every module under rtl/
package hne_pkg;

  // grid index width in the package types (room for up to 1024 per side)
  localparam int COORD_W  = 10;
  localparam int HEIGHT_W = 16;
  localparam int DIFF_W   = 17;
  localparam int Q14_W    = 15;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // one classified word passed from the front end to the back end
  typedef struct packed {
    logic                kind;
    logic [COORD_W-1:0]  col;
    logic [COORD_W-1:0]  row;
    logic                has_l;
    logic                has_r;
    logic                has_a;
    logic                has_b;
    logic [HEIGHT_W-1:0] height;
  } hne_item_t;

endpackage

/* rtl/hne_front.sv */
// front end: clamps coordinates and marks which neighbors exist
// depends on hne_pkg
module hne_front #(
  parameter int GRID_SIZE = 128
) (
  input  logic              in_kind,
  input  logic [6:0]        in_column,
  input  logic [6:0]        in_row,
  input  logic signed [15:0] in_height_value,
  output hne_pkg::hne_item_t item
);

  logic [hne_pkg::COORD_W-1:0] col_c;
  logic [hne_pkg::COORD_W-1:0] row_c;

  always_comb begin
    col_c = (32'(in_column) >= GRID_SIZE) ? hne_pkg::COORD_W'(GRID_SIZE - 1)
                                          : hne_pkg::COORD_W'(in_column);
    row_c = (32'(in_row) >= GRID_SIZE) ? hne_pkg::COORD_W'(GRID_SIZE - 1)
                                       : hne_pkg::COORD_W'(in_row);
    item.kind   = in_kind;
    item.col    = col_c;
    item.row    = row_c;
    item.has_l  = (col_c != '0);
    item.has_r  = (col_c != hne_pkg::COORD_W'(GRID_SIZE - 1));
    item.has_a  = (row_c != '0);
    item.has_b  = (row_c != hne_pkg::COORD_W'(GRID_SIZE - 1));
    item.height = in_height_value;
  end

endmodule

/* rtl/hne_queue.sv */
// two-entry queue between the front end and the back end
// depends on hne_pkg
module hne_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  hne_pkg::hne_item_t push_item,
  input  logic               pop,
  output hne_pkg::hne_item_t head_item,
  output logic               full,
  output logic               empty
);

  hne_pkg::hne_item_t slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign head_item = slot_r[rd_ptr_r];
  assign full      = (count_r == 2'd2);
  assign empty     = (count_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* rtl/hne_fetch.sv */
// back end, part one: height memory, writes and the five-point gather
// depends on hne_pkg
module hne_fetch #(
  parameter int GRID_SIZE = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  hne_pkg::hne_item_t q_item,
  output logic               q_pop,
  input  logic               solve_ready,
  output logic               solve_go,
  output logic signed [hne_pkg::DIFF_W-1:0] solve_dx,
  output logic signed [hne_pkg::DIFF_W-1:0] solve_dy
);

  localparam int DEPTH = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_HAND = 2'd2;

  logic [hne_pkg::HEIGHT_W-1:0] mem [DEPTH];
  logic [hne_pkg::HEIGHT_W-1:0] rdata_r;

  logic [1:0]    state_r;
  logic [2:0]    step_r;
  logic [AW-1:0] base_r;
  logic          has_l_r, has_r_r, has_a_r, has_b_r;
  logic signed [hne_pkg::HEIGHT_W-1:0] hc_r, hl_r, hr_r, ha_r, hb_r;

  logic [AW-1:0] item_addr;
  logic [AW-1:0] raddr;
  logic          mem_we;
  logic signed [hne_pkg::HEIGHT_W-1:0] left_v, right_v, above_v, below_v;

  assign item_addr = AW'(32'(q_item.row) * GRID_SIZE + 32'(q_item.col));
  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign mem_we    = q_pop && (q_item.kind == hne_pkg::KIND_WRITE);

  // center first, then left, right, above, below
  always_comb begin
    unique case (step_r)
      3'd0:    raddr = base_r;
      3'd1:    raddr = base_r - AW'(1);
      3'd2:    raddr = base_r + AW'(1);
      3'd3:    raddr = base_r - AW'(GRID_SIZE);
      default: raddr = base_r + AW'(GRID_SIZE);
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[item_addr] <= q_item.height;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_READ) begin
      unique case (step_r)
        3'd1:    hc_r <= rdata_r;
        3'd2:    hl_r <= rdata_r;
        3'd3:    hr_r <= rdata_r;
        3'd4:    ha_r <= rdata_r;
        3'd5:    hb_r <= rdata_r;
        default: hc_r <= hc_r;
      endcase
    end
    if (q_pop) begin
      base_r  <= item_addr;
      has_l_r <= q_item.has_l;
      has_r_r <= q_item.has_r;
      has_a_r <= q_item.has_a;
      has_b_r <= q_item.has_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= 3'd0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          step_r <= 3'd0;
          if (q_pop && q_item.kind == hne_pkg::KIND_QUERY) state_r <= ST_READ;
        end
        ST_READ: begin
          step_r <= step_r + 3'd1;
          if (step_r == 3'd5) state_r <= ST_HAND;
        end
        ST_HAND: begin
          if (solve_ready) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // missing neighbors fall back to the center height
  assign left_v  = has_l_r ? hl_r : hc_r;
  assign right_v = has_r_r ? hr_r : hc_r;
  assign above_v = has_a_r ? ha_r : hc_r;
  assign below_v = has_b_r ? hb_r : hc_r;

  assign solve_go = (state_r == ST_HAND) && solve_ready;
  assign solve_dx = hne_pkg::DIFF_W'(right_v) - hne_pkg::DIFF_W'(left_v);
  assign solve_dy = hne_pkg::DIFF_W'(below_v) - hne_pkg::DIFF_W'(above_v);

endmodule

/* rtl/hne_solve.sv */
// back end, part two: bit-serial divider and square root shared by
// the three normal components; depends on hne_pkg
module hne_solve (
  input  logic clk,
  input  logic rst_n,
  input  logic go,
  input  logic signed [hne_pkg::DIFF_W-1:0] dx,
  input  logic signed [hne_pkg::DIFF_W-1:0] dy,
  output logic ready,
  output logic out_valid,
  output logic signed [15:0] out_normal_x,
  output logic [14:0]        out_normal_y,
  output logic signed [15:0] out_normal_z
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_SQRT = 3'd4;
  localparam logic [2:0] ST_NEXT = 3'd5;

  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  localparam logic [34:0] UP_SQ = 35'd1 << 26;

  logic [2:0]  state_r;
  logic [1:0]  comp_r;
  logic [4:0]  cnt_r;
  logic signed [hne_pkg::DIFF_W-1:0] dx_r, dy_r;
  logic [15:0] adx_r, ady_r;
  logic [31:0] sx_r, sy_r;
  logic [33:0] s_r;
  logic [34:0] rem_r;
  logic [30:0] quo_r;
  logic [31:0] f_r;
  logic [19:0] srem_r;
  logic [15:0] root_r;
  logic        out_valid_r;
  logic signed [15:0] nx_r, nz_r;
  logic [14:0] ny_r;

  logic [hne_pkg::DIFF_W-1:0] dx_abs, dy_abs;
  logic [34:0] div_t;
  logic        div_ge;
  logic [30:0] quo_nxt;
  logic [19:0] sq_sh, sq_trial;
  logic [14:0] q;
  logic [34:0] a2_next;

  assign dx_abs = dx[hne_pkg::DIFF_W-1] ? -dx : dx;
  assign dy_abs = dy[hne_pkg::DIFF_W-1] ? -dy : dy;

  // first quotient bit compares a^2 itself; later bits shift in zeros
  assign div_t   = (cnt_r == 5'd0) ? rem_r : {rem_r[33:0], 1'b0};
  assign div_ge  = (div_t >= {1'b0, s_r});
  assign quo_nxt = {quo_r[29:0], div_ge};

  assign sq_sh    = {srem_r[17:0], f_r[31:30]};
  assign sq_trial = {2'b00, root_r, 2'b01};

  // nearest rounding: largest q with 2q-1 <= isqrt(floor(2^30 a^2 / s))
  assign q = 15'((17'(root_r) + 17'd1) >> 1);

  always_comb begin
    unique case (comp_r)
      COMP_X:  a2_next = UP_SQ;
      default: a2_next = 35'(sy_r);
    endcase
  end

  assign ready        = (state_r == ST_IDLE);
  assign out_valid    = out_valid_r;
  assign out_normal_x = nx_r;
  assign out_normal_y = ny_r;
  assign out_normal_z = nz_r;

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        dx_r  <= dx;
        dy_r  <= dy;
        adx_r <= dx_abs[15:0];
        ady_r <= dy_abs[15:0];
      end
      ST_SQ: begin
        sx_r <= adx_r * adx_r;
        sy_r <= ady_r * ady_r;
      end
      ST_SUM: begin
        s_r   <= 34'(sx_r) + 34'(sy_r) + UP_SQ[33:0];
        rem_r <= 35'(sx_r);
      end
      ST_DIV: begin
        rem_r <= div_ge ? (div_t - {1'b0, s_r}) : div_t;
        quo_r <= quo_nxt;
        if (cnt_r == 5'd30) begin
          f_r    <= {1'b0, quo_nxt};
          srem_r <= '0;
          root_r <= '0;
        end
      end
      ST_SQRT: begin
        f_r <= {f_r[29:0], 2'b00};
        if (sq_sh >= sq_trial) begin
          srem_r <= sq_sh - sq_trial;
          root_r <= {root_r[14:0], 1'b1};
        end else begin
          srem_r <= sq_sh;
          root_r <= {root_r[14:0], 1'b0};
        end
      end
      ST_NEXT: begin
        rem_r <= a2_next;
        unique case (comp_r)
          COMP_X: nx_r <= (!dx_r[hne_pkg::DIFF_W-1] && dx_r != '0) ? -16'(q) : 16'(q);
          COMP_Y: ny_r <= q;
          default: nz_r <= (!dy_r[hne_pkg::DIFF_W-1] && dy_r != '0) ? -16'(q) : 16'(q);
        endcase
      end
      default: rem_r <= rem_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      comp_r      <= COMP_X;
      cnt_r       <= 5'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: if (go) state_r <= ST_SQ;
        ST_SQ:   state_r <= ST_SUM;
        ST_SUM: begin
          comp_r  <= COMP_X;
          cnt_r   <= 5'd0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt_r == 5'd30) begin
            cnt_r   <= 5'd0;
            state_r <= ST_SQRT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_SQRT: begin
          if (cnt_r == 5'd15) begin
            cnt_r   <= 5'd0;
            state_r <= ST_NEXT;
          end else begin
            cnt_r <= cnt_r + 5'd1;
          end
        end
        ST_NEXT: begin
          if (comp_r == COMP_Z) begin
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end else begin
            comp_r  <= comp_r + 2'd1;
            state_r <= ST_DIV;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/heightmap_normal_engine.sv */
// A write stores one Q3.12 height and finishes as soon as the back end pops
// it from the two-word queue. A query gathers five heights from the
// height memory one address at a time, then passes through the shared
// bit-serial unit (a squaring step and a summing step, then for each of the
// three components a divide, a square root and a finish step). busy is high
// while the queue is full. out_valid marks each result for exactly one cycle
// and cannot be held off; the normal fields are only meaningful in that
// cycle.
// depends on hne_pkg, hne_front, hne_queue, hne_fetch, hne_solve
module heightmap_normal_engine #(
  parameter int GRID_SIZE = 128
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic [6:0]         in_column,
  input  logic [6:0]         in_row,
  input  logic signed [15:0] in_height_value,
  output logic               out_valid,
  output logic signed [15:0] out_normal_x,
  output logic [14:0]        out_normal_y,
  output logic signed [15:0] out_normal_z
);

  hne_pkg::hne_item_t front_item;
  hne_pkg::hne_item_t head_item;
  logic q_full, q_empty, q_pop, q_push;
  logic solve_ready, solve_go;
  logic signed [hne_pkg::DIFF_W-1:0] solve_dx, solve_dy;

  assign busy   = q_full;
  assign q_push = start && !q_full;

  hne_front #(.GRID_SIZE(GRID_SIZE)) u_front (
    .in_kind         (in_kind),
    .in_column       (in_column),
    .in_row          (in_row),
    .in_height_value (in_height_value),
    .item            (front_item)
  );

  hne_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (front_item),
    .pop       (q_pop),
    .head_item (head_item),
    .full      (q_full),
    .empty     (q_empty)
  );

  hne_fetch #(.GRID_SIZE(GRID_SIZE)) u_fetch (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_item      (head_item),
    .q_pop       (q_pop),
    .solve_ready (solve_ready),
    .solve_go    (solve_go),
    .solve_dx    (solve_dx),
    .solve_dy    (solve_dy)
  );

  hne_solve u_solve (
    .clk          (clk),
    .rst_n        (rst_n),
    .go           (solve_go),
    .dx           (solve_dx),
    .dy           (solve_dy),
    .ready        (solve_ready),
    .out_valid    (out_valid),
    .out_normal_x (out_normal_x),
    .out_normal_y (out_normal_y),
    .out_normal_z (out_normal_z)
  );

`ifndef SYNTHESIS
  a_accept_fills_queue: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> !q_empty)
    else $error("accepted word missing from queue");

  a_go_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    solve_go |-> solve_ready)
    else $error("query handed to a busy solver");

  a_result_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");
`endif

endmodule

/* bench/heightmap_normal_engine_tb.sv */
// self-checking bench for heightmap_normal_engine: writes heights, queries normals
// and checks each normal word against a local predictor or a pinned value; depends on hne_pkg and the rtl
module heightmap_normal_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N         = 128;
  localparam int RAND_ITEMS = 1600;
  localparam int WD_LIMIT  = 4000;
  localparam int TAIL      = 400;

  typedef struct packed {
    logic signed [15:0] nx;
    logic [14:0]        ny;
    logic signed [15:0] nz;
  } normal_t;

  typedef struct {
    logic        kind;
    int          col;
    int          row;
    int          hgt;
    bit          pinned;
    normal_t     res;
  } stim_row_t;

  logic               clk, rst_n, start, busy;
  logic               in_kind;
  logic [6:0]         in_column, in_row;
  logic signed [15:0] in_height_value;
  logic               out_valid;
  logic signed [15:0] out_normal_x, out_normal_z;
  logic [14:0]        out_normal_y;

  // typed expectation travels with the word it belongs to
  logic    pin_en;
  normal_t pin_val;

  logic signed [15:0] heights[0:N*N-1];  // predictor copy of the height store
  bit                 gen_written[0:N*N-1];
  normal_t            normal_q[$];
  int                 err_cnt;
  int                 idle_cnt;

  heightmap_normal_engine #(.GRID_SIZE(N)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_kind(in_kind), .in_column(in_column), .in_row(in_row),
    .in_height_value(in_height_value), .out_valid(out_valid),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // largest q in [0,16384] with (2q-1)^2 * s <= 2^30 * a^2, i.e. round to nearest
  function automatic int unit_mag(longint unsigned a, longint unsigned s);
    longint unsigned num, k;
    int lo, hi, mid;
    num = (a * a) << 30;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      k = 2 * longint'(mid) - 1;
      if (k * k * s <= num) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic logic signed [15:0] signed_unit(int m, longint unsigned s);
    int q;
    q = unit_mag(longint'(m < 0 ? -m : m), s);
    return (m < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic normal_t surface_normal(int c, int r);
    int h, lf, rt, ab, bl, dx, dy;
    longint unsigned s;
    normal_t n;
    h  = heights[r*N + c];
    lf = (c > 0)   ? heights[r*N + c - 1] : h;
    rt = (c < N-1) ? heights[r*N + c + 1] : h;
    ab = (r > 0)   ? heights[(r-1)*N + c] : h;
    bl = (r < N-1) ? heights[(r+1)*N + c] : h;
    dx = rt - lf;
    dy = bl - ab;
    s = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy) + (64'd1 << 26);
    n.nx = signed_unit(-dx, s);
    n.ny = 15'(unit_mag(64'd1 << 13, s));
    n.nz = signed_unit(-dy, s);
    return n;
  endfunction

  // accept words, predict, check results, watchdog
  always @(posedge clk) begin
    normal_t got, want;
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (start && !busy) begin
        if (in_kind == hne_pkg::KIND_WRITE)
          heights[int'(in_row)*N + int'(in_column)] = in_height_value;
        else
          normal_q.push_back(pin_en ? pin_val
                                    : surface_normal(int'(in_column), int'(in_row)));
      end
      if (out_valid) begin
        got = '{out_normal_x, out_normal_y, out_normal_z};
        if (normal_q.size() == 0) begin
          $error("normal word with nothing expected");
          err_cnt++;
        end else begin
          want = normal_q.pop_front();
          if (got.nx !== want.nx) begin
            $error("normal_x: expected %0d, got %0d", want.nx, got.nx);
            err_cnt++;
          end
          if (got.ny !== want.ny) begin
            $error("normal_y: expected %0d, got %0d", want.ny, got.ny);
            err_cnt++;
          end
          if (got.nz !== want.nz) begin
            $error("normal_z: expected %0d, got %0d", want.nz, got.nz);
            err_cnt++;
          end
        end
      end
      if (idle_cnt >= WD_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_word(logic k, int c, int r, int h, bit pin, normal_t pv);
    start           <= 1'b1;
    in_kind         <= k;
    in_column       <= 7'(c);
    in_row          <= 7'(r);
    in_height_value <= 16'(h);
    pin_en          <= pin;
    pin_val         <= pv;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    if (k == hne_pkg::KIND_WRITE) gen_written[r*N + c] = 1'b1;
  endtask

  int burst_left;

  // bursts of random length, most of them separated by random gaps
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(0, 3) == 0 ? 40 : $urandom_range(0, 12);
    if ($urandom_range(0, 2) != 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  function automatic int rand_height();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32767 : -32768;
      1, 2: return int'($urandom_range(0, 1023)) - 512;
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  // first unwritten cell in the neighborhood, or -1 when a query is legal
  function automatic int missing_at(int c, int r);
    if (!gen_written[r*N + c]) return r*N + c;
    if (c > 0   && !gen_written[r*N + c - 1]) return r*N + c - 1;
    if (c < N-1 && !gen_written[r*N + c + 1]) return r*N + c + 1;
    if (r > 0   && !gen_written[(r-1)*N + c]) return (r-1)*N + c;
    if (r < N-1 && !gen_written[(r+1)*N + c]) return (r+1)*N + c;
    return -1;
  endfunction

  stim_row_t plan[$];
  localparam normal_t FLAT = '{16'sd0, 15'd16384, 16'sd0};
  localparam normal_t NONE = '{16'sd0, 15'd0, 16'sd0};

  initial begin
    int c, r, m, hc, hr;
    int hot_c[4], hot_r[4];
    rst_n = 1'b0;
    start = 1'b0;
    in_kind = hne_pkg::KIND_WRITE;
    in_column = '0;
    in_row = '0;
    in_height_value = '0;
    pin_en = 1'b0;
    pin_val = NONE;
    err_cnt = 0;
    idle_cnt = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // flat corner, then extremes at both corners and an interior cell
    plan = '{
      '{hne_pkg::KIND_WRITE, 0, 0, 0, 0, NONE},
      '{hne_pkg::KIND_WRITE, 1, 0, 0, 0, NONE},
      '{hne_pkg::KIND_WRITE, 0, 1, 0, 0, NONE},
      '{hne_pkg::KIND_QUERY, 0, 0, 12345, 1, FLAT},
      '{hne_pkg::KIND_WRITE, 0, 0, -32768, 0, NONE},
      '{hne_pkg::KIND_WRITE, 1, 0, 32767, 0, NONE},
      '{hne_pkg::KIND_QUERY, 0, 0, 0, 0, NONE},
      '{hne_pkg::KIND_WRITE, 127, 127, 32767, 0, NONE},
      '{hne_pkg::KIND_WRITE, 126, 127, 32767, 0, NONE},
      '{hne_pkg::KIND_WRITE, 127, 126, 32767, 0, NONE},
      '{hne_pkg::KIND_QUERY, 127, 127, -1, 1, FLAT},
      '{hne_pkg::KIND_WRITE, 126, 127, -32768, 0, NONE},
      '{hne_pkg::KIND_WRITE, 127, 126, -32768, 0, NONE},
      '{hne_pkg::KIND_QUERY, 127, 127, 0, 0, NONE},
      '{hne_pkg::KIND_WRITE, 5, 5, 100, 0, NONE},
      '{hne_pkg::KIND_WRITE, 4, 5, 32767, 0, NONE},
      '{hne_pkg::KIND_WRITE, 6, 5, -32768, 0, NONE},
      '{hne_pkg::KIND_WRITE, 5, 4, -32768, 0, NONE},
      '{hne_pkg::KIND_WRITE, 5, 6, 32767, 0, NONE},
      '{hne_pkg::KIND_QUERY, 5, 5, 0, 0, NONE},
      '{hne_pkg::KIND_WRITE, 4, 5, 4096, 0, NONE},
      '{hne_pkg::KIND_WRITE, 6, 5, 4096, 0, NONE},
      '{hne_pkg::KIND_QUERY, 5, 5, 0, 0, NONE}
    };
    foreach (plan[i])
      send_word(plan[i].kind, plan[i].col, plan[i].row, plan[i].hgt,
                plan[i].pinned, plan[i].res);

    // hold off until the engine has drained
    start <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk);
    @(posedge clk);

    foreach (hot_c[i]) begin
      hot_c[i] = $urandom_range(0, N-1);
      hot_r[i] = $urandom_range(0, N-1);
    end
    hot_c[0] = 0;
    hot_r[0] = N-1;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      pace();
      if ($urandom_range(0, 9) == 0) begin
        // stray write anywhere on the grid
        send_word(hne_pkg::KIND_WRITE, $urandom_range(0, N-1), $urandom_range(0, N-1),
                  rand_height(), 0, NONE);
        continue;
      end
      m = $urandom_range(0, 3);
      hc = hot_c[m] + int'($urandom_range(0, 6)) - 3;
      hr = hot_r[m] + int'($urandom_range(0, 6)) - 3;
      c = hc < 0 ? 0 : (hc > N-1 ? N-1 : hc);
      r = hr < 0 ? 0 : (hr > N-1 ? N-1 : hr);
      if ($urandom_range(0, 15) == 0) begin
        c = $urandom_range(0, N-1);
        r = $urandom_range(0, N-1);
      end
      m = missing_at(c, r);
      if (m >= 0)
        send_word(hne_pkg::KIND_WRITE, m % N, m / N, rand_height(), 0, NONE);
      else if ($urandom_range(0, 9) < 6)
        send_word(hne_pkg::KIND_QUERY, c, r, int'($urandom), 0, NONE);
      else
        send_word(hne_pkg::KIND_WRITE, c, r, rand_height(), 0, NONE);
      if ($urandom_range(0, 199) == 0)
        foreach (hot_c[i]) begin
          hot_c[i] = $urandom_range(0, N-1);
          hot_r[i] = $urandom_range(0, N-1);
        end
    end

    start <= 1'b0;
    while (normal_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
